// ----- src/ycdg_pkg.sv -----
// ----------------------------------------------------------------------------
// ycdg_pkg
// Shared constants, types and fixed-point helpers for the YUV distance block.
// ----------------------------------------------------------------------------
package ycdg_pkg;

  localparam int unsigned FracBits = 24;
  localparam int unsigned MantBits = 30;
  localparam int unsigned SumW     = 18;
  localparam int unsigned LogW     = 29;  // 5 integer bits, 24 fraction bits

  localparam logic [2:0] RegRefLuma  = 3'd0;
  localparam logic [2:0] RegRefBlue  = 3'd1;
  localparam logic [2:0] RegRefRed   = 3'd2;
  localparam logic [2:0] RegGain     = 3'd3;
  localparam logic [2:0] RegExponent = 3'd4;

  localparam logic [15:0] GainReset = 16'd4096;
  localparam logic [14:0] ExpReset  = 15'd4096;

  // elaboration-time integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    begin
      x = x_in;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      isqrt64 = r;
    end
  endfunction

  // elaboration-time log2, same squaring procedure as the pipeline
  function automatic logic [LogW-1:0] log2_fix(input logic [31:0] x);
    logic [63:0]         m;
    logic [FracBits-1:0] frac;
    logic [4:0]          e;
    begin
      e = '0;
      for (int i = 0; i < 32; i++) if (x[i]) e = 5'(i);
      m = ({32'd0, x} << MantBits) >> e;
      frac = '0;
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> MantBits;
        frac = {frac[22:0], (m >= (64'd2 << MantBits))};
        if (m >= (64'd2 << MantBits)) m = m >> 1;
      end
      log2_fix = {e, frac};
    end
  endfunction

  function automatic logic [23:0][31:0] root_table();
    logic [63:0]       c;
    logic [23:0][31:0] tab;
    begin
      c = 64'd1 << 31;
      for (int k = 0; k < 24; k++) begin
        c = isqrt64(c << MantBits);
        tab[k] = c[31:0];
      end
      root_table = tab;
    end
  endfunction

  // log2(65025) with 24 fraction bits, from the same squaring procedure
  localparam logic [LogW-1:0] LogRef = log2_fix(32'd65025);

  // 2^(2^-k) with 30 fraction bits, k = 1..24 (index k-1)
  localparam logic [23:0][31:0] RootTab = root_table();

  typedef struct packed {
    logic [7:0]  ref_luma;
    logic [7:0]  ref_blue;
    logic [7:0]  ref_red;
    logic [15:0] gain;
    logic [14:0] exponent;
  } cfg_t;

  // one squaring step of the log2 mantissa loop
  function automatic logic [31:0] log_step(input logic [31:0] m_in, output logic bit_o);
    logic [63:0] sq;
    logic [33:0] t;
    begin
      sq = {32'd0, m_in} * {32'd0, m_in};
      t  = sq[63:30];
      bit_o = t[31];
      log_step = t[31] ? t[32:1] : t[31:0];
    end
  endfunction

  // one exp2 multiply step
  function automatic logic [31:0] exp_step(input logic [31:0] p_in, input logic [4:0] k,
                                           input logic sel);
    logic [63:0] pr;
    begin
      pr = {32'd0, p_in} * {32'd0, RootTab[k]};
      exp_step = sel ? pr[61:30] : p_in;
    end
  endfunction

endpackage

// ----- src/yuv_color_distance_gamma_top.sv -----
// ----------------------------------------------------------------------------
// yuv_color_distance_gamma_top
// Colour distance to a reference colour, gain and gamma shaped, as gray level.
// ----------------------------------------------------------------------------
// An accepted start travels down the valid pipe to the done strobe, in step with its gray level.
// Throughput: one pixel per cycle; busy is never raised, results cannot stall.
// Each of the 24 log2 squarings and 24 exp2 multiplies owns one stage.
// Reset clears the valid pipe and loads the register reset values.
module yuv_color_distance_gamma_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  luma_sample_i,
  input  logic [7:0]  blue_diff_sample_i,
  input  logic [7:0]  red_diff_sample_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [7:0]  gray_level_o
);

  localparam int unsigned NStg = 56;

  ycdg_pkg::cfg_t cfg_q;
  logic [NStg-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_luma <= '0;
      cfg_q.ref_blue <= '0;
      cfg_q.ref_red  <= '0;
      cfg_q.gain     <= ycdg_pkg::GainReset;
      cfg_q.exponent <= ycdg_pkg::ExpReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ycdg_pkg::RegRefLuma:  cfg_q.ref_luma <= cfg_data_i[7:0];
        ycdg_pkg::RegRefBlue:  cfg_q.ref_blue <= cfg_data_i[7:0];
        ycdg_pkg::RegRefRed:   cfg_q.ref_red  <= cfg_data_i[7:0];
        ycdg_pkg::RegGain:     cfg_q.gain     <= cfg_data_i;
        ycdg_pkg::RegExponent: cfg_q.exponent <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[NStg-2:0], start};
  end

  // stage 0: squared differences
  logic [17:0] sq_y_q, sq_u_q, sq_v_q;
  logic [8:0]  dy, du, dv;
  always_comb begin
    dy = {1'b0, luma_sample_i} - {1'b0, cfg_q.ref_luma};
    du = {1'b0, blue_diff_sample_i} - {1'b0, cfg_q.ref_blue};
    dv = {1'b0, red_diff_sample_i} - {1'b0, cfg_q.ref_red};
  end
  always_ff @(posedge clk_i) begin
    sq_y_q <= 18'($signed({{9{dy[8]}}, dy}) * $signed({{9{dy[8]}}, dy}));
    sq_u_q <= 18'($signed({{9{du[8]}}, du}) * $signed({{9{du[8]}}, du}));
    sq_v_q <= 18'($signed({{9{dv[8]}}, dv}) * $signed({{9{dv[8]}}, dv}));
  end

  // stage 1: sum
  logic [17:0] s_q;
  always_ff @(posedge clk_i) s_q <= sq_y_q + sq_u_q + sq_v_q;

  // stage 2: normalise
  logic [4:0]  e_d;
  logic [31:0] m0_q;
  logic [4:0]  e_q;
  logic        zero_q;
  always_comb begin
    e_d = '0;
    for (int i = 0; i < 18; i++) if (s_q[i]) e_d = 5'(i);
  end
  always_ff @(posedge clk_i) begin
    m0_q   <= 32'(({30'd0, s_q} << 30) >> e_d);
    e_q    <= e_d;
    zero_q <= (s_q == '0);
  end

  // stages 3..26: log2 squarings
  logic [31:0] lm_q [25];
  logic [23:0] lf_q [25];
  logic [4:0]  le_q [25];
  logic        lz_q [25];
  assign lm_q[0] = m0_q;
  assign lf_q[0] = '0;
  assign le_q[0] = e_q;
  assign lz_q[0] = zero_q;
  for (genvar g = 0; g < 24; g++) begin : g_log
    logic [31:0] m_d;
    logic        b_d;
    always_comb m_d = ycdg_pkg::log_step(lm_q[g], b_d);
    always_ff @(posedge clk_i) begin
      lm_q[g+1] <= m_d;
      lf_q[g+1] <= {lf_q[g][22:0], b_d};
      le_q[g+1] <= le_q[g];
      lz_q[g+1] <= lz_q[g];
    end
  end

  // stage 27: diff; stage 28: product
  logic signed [29:0] diff_q;
  logic               z27_q, z28_q;
  logic signed [45:0] prod_q;
  always_ff @(posedge clk_i) begin
    diff_q <= $signed({1'b0, le_q[24], lf_q[24]}) - $signed({1'b0, ycdg_pkg::LogRef});
    z27_q  <= lz_q[24];
    prod_q <= $signed({1'b0, cfg_q.exponent}) * diff_q;
    z28_q  <= z27_q;
  end

  // stage 29: split t = n + f (arithmetic shift is floor)
  logic signed [32:0] t_d;
  logic signed [8:0]  n_q;
  logic [23:0]        f_q;
  logic               z29_q;
  assign t_d = 33'(prod_q >>> 13);
  always_ff @(posedge clk_i) begin
    n_q   <= t_d[32:24];
    f_q   <= t_d[23:0];
    z29_q <= z28_q;
  end

  // stages 30..53: exp2 multiplies
  logic [31:0]       ep_q [25];
  logic [23:0]       ef_q [25];
  logic signed [8:0] en_q [25];
  logic              ez_q [25];
  assign ep_q[0] = 32'd1 << 30;
  assign ef_q[0] = f_q;
  assign en_q[0] = n_q;
  assign ez_q[0] = z29_q;
  for (genvar g = 0; g < 24; g++) begin : g_exp
    always_ff @(posedge clk_i) begin
      ep_q[g+1] <= ycdg_pkg::exp_step(ep_q[g], 5'(g), ef_q[g][23-g]);
      ef_q[g+1] <= ef_q[g];
      en_q[g+1] <= en_q[g];
      ez_q[g+1] <= ez_q[g];
    end
  end

  // stage 54: gain product with special case
  logic [47:0]       v_q;
  logic signed [8:0] n54_q;
  logic              z54_q;
  always_ff @(posedge clk_i) begin
    if (ez_q[24]) v_q <= (cfg_q.exponent == '0) ? {2'd0, cfg_q.gain, 30'd0} : '0;
    else          v_q <= {16'd0, ep_q[24]} * {32'd0, cfg_q.gain};
    n54_q <= en_q[24];
    z54_q <= ez_q[24];
  end

  // stage 55: shift, clamp, scale
  logic [63:0] vs;
  logic [7:0]  g_d;
  logic [71:0] sc;
  always_comb begin
    vs = {16'd0, v_q};
    if (!z54_q) begin
      if (!n54_q[8]) begin
        if (n54_q > 9'sd15) vs = (v_q != '0) ? (64'd1 << 42) : '0;
        else                vs = {16'd0, v_q} << n54_q[3:0];
      end else if (n54_q <= -9'sd64) begin
        vs = '0;
      end else begin
        vs = {16'd0, v_q} >> 6'(-n54_q);
      end
    end
    sc  = {8'd0, vs} * 72'd255;
    g_d = (vs >= (64'd1 << 42)) ? 8'd255 : sc[49:42];
  end
  always_ff @(posedge clk_i) gray_level_o <= g_d;

  assign done_o = vld_q[NStg-1];

  a_busy_low: assert property (@(posedge clk_i) !busy) else $error("busy raised");
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##55 done_o) else $error("lost beat");
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[NStg-2])) else $error("invented beat");

endmodule

// ----- bench/tb_yuv_color_distance_gamma_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv_color_distance_gamma_top
// Self-checking bench: a directed table then random pixels under several
// register settings, each gray level checked against the table or a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_yuv_color_distance_gamma_top;

  localparam int unsigned RandomItems = 1250;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned StallLimit  = 4000;

  typedef struct {
    int unsigned setting;
    logic [7:0]  y;
    logic [7:0]  u;
    logic [7:0]  v;
    bit          known;
    logic [7:0]  gray;
  } pixel_row_t;

  typedef struct {
    logic [7:0]  ref_y;
    logic [7:0]  ref_u;
    logic [7:0]  ref_v;
    logic [15:0] gain;
    logic [14:0] expo;
  } setting_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  luma_sample_i = '0;
  logic [7:0]  blue_diff_sample_i = '0;
  logic [7:0]  red_diff_sample_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        done_o;
  logic [7:0]  gray_level_o;

  yuv_color_distance_gamma_top dut (
    .clk_i, .rst_ni, .start, .busy,
    .luma_sample_i, .blue_diff_sample_i, .red_diff_sample_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .done_o, .gray_level_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the block's registers
  logic [7:0]  sh_ref_y = 8'd0, sh_ref_u = 8'd0, sh_ref_v = 8'd0;
  logic [15:0] sh_gain = ycdg_pkg::GainReset;
  logic [14:0] sh_expo = ycdg_pkg::ExpReset;

  longint unsigned root_q30 [1:24];
  logic [7:0]      gray_pending [$];
  int unsigned     mismatches = 0;
  int unsigned     stall_cycles = 0;

  setting_t   settings [6];
  pixel_row_t pixel_table [$];

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // log2 with 24 fraction bits, by repeated squaring of the mantissa
  function automatic longint unsigned log2_q24(int unsigned x);
    int unsigned     e;
    longint unsigned m, frac;
    e = 0;
    frac = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = (longint'(x) << ycdg_pkg::MantBits) >> e;
    for (int i = 0; i < ycdg_pkg::FracBits; i++) begin
      m = (m * m) >> ycdg_pkg::MantBits;
      frac <<= 1;
      if (m >= (64'd2 << ycdg_pkg::MantBits)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return (longint'(e) << ycdg_pkg::FracBits) | frac;
  endfunction

  function automatic logic [7:0] predict_gray(logic [7:0] y, logic [7:0] u, logic [7:0] v);
    int              dy, du, dv;
    int unsigned     s;
    longint          diff, prod, n;
    longint unsigned f, p, t, tm, lvl, one42, mask;
    dy = int'(y) - int'(sh_ref_y);
    du = int'(u) - int'(sh_ref_u);
    dv = int'(v) - int'(sh_ref_v);
    s = dy * dy + du * du + dv * dv;
    one42 = 64'd1 << 42;
    mask = (64'd1 << ycdg_pkg::FracBits) - 1;
    if (s == 0) begin
      lvl = (sh_expo == 0) ? (longint'(sh_gain) << ycdg_pkg::MantBits) : 0;
    end else begin
      diff = longint'(log2_q24(s)) - longint'(log2_q24(65025));
      prod = longint'(sh_expo) * diff;
      if (prod >= 0) begin
        t = prod >>> 13;
        n = longint'(t >> ycdg_pkg::FracBits);
        f = t & mask;
      end else begin
        tm = (longint'(-prod) + 8191) >> 13;
        n = -longint'(tm >> ycdg_pkg::FracBits);
        f = 0;
        if ((tm & mask) != 0) begin
          n -= 1;
          f = (64'd1 << ycdg_pkg::FracBits) - (tm & mask);
        end
      end
      p = 64'd1 << ycdg_pkg::MantBits;
      for (int k = 1; k <= ycdg_pkg::FracBits; k++)
        if ((f >> (ycdg_pkg::FracBits - k)) & 1) p = (p * root_q30[k]) >> ycdg_pkg::MantBits;
      lvl = longint'(sh_gain) * p;
      if (n >= 0) begin
        if (n > 15) lvl = (lvl != 0) ? one42 : 0;
        else lvl <<= n;
      end else if (-n >= 64) begin
        lvl = 0;
      end else begin
        lvl >>= -n;
      end
    end
    if (lvl >= one42) return 8'd255;
    return 8'((lvl * 255) >> 42);
  endfunction

  // checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (gray_pending.size() == 0) begin
          $display("%0t: unexpected gray level, expected none, actual %0d", $time,
                   gray_level_o);
          mismatches++;
        end else begin
          if (gray_level_o !== gray_pending[0]) begin
            $display("%0t: gray_level mismatch, expected %0d, actual %0d", $time,
                     gray_pending[0], gray_level_o);
            mismatches++;
          end
          void'(gray_pending.pop_front());
        end
      end
      if (done_o || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      ycdg_pkg::RegRefLuma:  sh_ref_y = data[7:0];
      ycdg_pkg::RegRefBlue:  sh_ref_u = data[7:0];
      ycdg_pkg::RegRefRed:   sh_ref_v = data[7:0];
      ycdg_pkg::RegGain:     sh_gain  = data;
      ycdg_pkg::RegExponent: sh_expo  = data[14:0];
      default: ;
    endcase
  endtask

  // drain the pipe, then load a full setting; upper data bits carry junk
  task automatic apply_setting(setting_t st);
    @(negedge clk_i);
    start <= 1'b0;
    while (gray_pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    reg_write(ycdg_pkg::RegRefLuma, {8'($urandom), st.ref_y});
    reg_write(ycdg_pkg::RegRefBlue, {8'($urandom), st.ref_u});
    reg_write(ycdg_pkg::RegRefRed, {8'($urandom), st.ref_v});
    reg_write(ycdg_pkg::RegGain, st.gain);
    reg_write(ycdg_pkg::RegExponent, {1'($urandom), st.expo});
    reg_write(3'($urandom_range(5, 7)), 16'($urandom));  // unmapped index
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v, bit known,
                            logic [7:0] gray, int unsigned gap);
    @(negedge clk_i);
    start              <= 1'b1;
    luma_sample_i      <= y;
    blue_diff_sample_i <= u;
    red_diff_sample_i  <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    gray_pending.push_back(known ? gray : predict_gray(y, u, v));
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [7:0] near_value(logic [7:0] centre);
    int c;
    c = int'(centre) + int'($urandom_range(0, 8)) - 4;
    return (c < 0) ? 8'd0 : (c > 255) ? 8'd255 : 8'(c);
  endfunction

  initial begin
    setting_t    st;
    int unsigned cur, gap, burst;
    logic [7:0]  y, u, v;

    for (int k = 1; k <= 24; k++)
      root_q30[k] = isqrt(((k == 1) ? (64'd1 << 31) : root_q30[k - 1]) << ycdg_pkg::MantBits);

    settings[0] = '{8'd0, 8'd0, 8'd0, 16'd4096, 15'd4096};
    settings[1] = '{8'd10, 8'd20, 8'd30, 16'd2048, 15'd0};      // zero exponent
    settings[2] = '{8'd255, 8'd255, 8'd255, 16'd40960, 15'd20480};
    settings[3] = '{8'd128, 8'd128, 8'd128, 16'd41, 15'd4096};
    settings[4] = '{8'd0, 8'd255, 8'd0, 16'd65535, 15'd32767};   // beyond range
    settings[5] = '{8'd77, 8'd0, 8'd200, 16'd0, 15'd100};        // zero gain

    pixel_table = '{
      '{0, 8'd0, 8'd0, 8'd0, 1, 8'd0},          // exact match
      '{0, 8'd255, 8'd255, 8'd255, 1, 8'd255},  // beyond unit distance
      '{0, 8'd255, 8'd0, 8'd0, 1, 8'd255},      // unit distance
      '{0, 8'd1, 8'd0, 8'd0, 0, 8'd0},
      '{0, 8'd0, 8'd128, 8'd64, 0, 8'd0},
      '{1, 8'd10, 8'd20, 8'd30, 1, 8'd127},     // match, zero exponent
      '{1, 8'd0, 8'd255, 8'd0, 1, 8'd127},
      '{1, 8'd11, 8'd20, 8'd30, 1, 8'd127},
      '{2, 8'd255, 8'd255, 8'd255, 1, 8'd0},
      '{2, 8'd0, 8'd0, 8'd0, 1, 8'd255},
      '{2, 8'd254, 8'd255, 8'd255, 0, 8'd0},
      '{2, 8'd128, 8'd200, 8'd255, 0, 8'd0},
      '{3, 8'd128, 8'd128, 8'd128, 1, 8'd0},
      '{3, 8'd0, 8'd0, 8'd0, 0, 8'd0},
      '{3, 8'd255, 8'd255, 8'd255, 0, 8'd0},
      '{3, 8'd129, 8'd127, 8'd128, 0, 8'd0},
      '{4, 8'd0, 8'd255, 8'd0, 1, 8'd0},
      '{4, 8'd255, 8'd0, 8'd255, 0, 8'd0},
      '{4, 8'd1, 8'd255, 8'd0, 0, 8'd0},
      '{5, 8'd77, 8'd0, 8'd200, 1, 8'd0},
      '{5, 8'd0, 8'd255, 8'd0, 1, 8'd0},
      '{5, 8'd170, 8'd85, 8'd15, 1, 8'd0}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cur = 0;
    foreach (pixel_table[i]) begin
      if (pixel_table[i].setting != cur) begin
        cur = pixel_table[i].setting;
        apply_setting(settings[cur]);
      end
      send_pixel(pixel_table[i].y, pixel_table[i].u, pixel_table[i].v,
                 pixel_table[i].known, pixel_table[i].gray, $urandom_range(0, 3));
    end

    burst = 0;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 125 == 0) begin
        st.ref_y = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        st.ref_u = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom);
        st.ref_v = 8'($urandom);
        case ($urandom_range(0, 5))
          0: st.gain = 16'd41;
          1: st.gain = 16'd40960;
          2: st.gain = 16'($urandom);
          default: st.gain = 16'($urandom_range(41, 40960));
        endcase
        case ($urandom_range(0, 5))
          0: st.expo = 15'd0;
          1: st.expo = 15'd20480;
          2: st.expo = 15'($urandom);
          default: st.expo = 15'($urandom_range(0, 20480));
        endcase
        apply_setting(st);
      end
      if (burst == 0) burst = $urandom_range(1, 40);
      burst--;
      // alternate busy stretches with idle ones
      gap = ((i / 60) % 3 == 0) ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 9) < 6) begin
        y = near_value(sh_ref_y);
        u = near_value(sh_ref_u);
        v = near_value(sh_ref_v);
      end else begin
        y = 8'($urandom);
        u = 8'($urandom);
        v = 8'($urandom);
      end
      send_pixel(y, u, v, 0, 8'd0, gap);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (gray_pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
